FILE: sv/bldc_pkg.sv
// Package with the shared constants, codes and types of the backward LZ decompressor.
`default_nettype none
package bldc_pkg;

   // Sizes of the history window, the per-request byte limit and the length fields.
   localparam int WindowBytes = 8192;
   localparam int WinAw       = $clog2(WindowBytes);
   localparam int MaxBytes    = 64;
   localparam int CntW        = $clog2(MaxBytes + 1);
   localparam int LenW        = 24;
   localparam int AccW        = 13;
   localparam int WordW       = 32;
   localparam int LeftW       = 6;
   localparam int CfgW        = 4;
   localparam int NumCfg      = 4;

   // Field widths and special values of the token format.
   localparam logic [CfgW-1:0] MaxOffBits = 4'd13;
   localparam logic [CfgW-1:0] EscOffBits = 4'd7;
   localparam logic [CfgW-1:0] LenCodeBits = 4'd2;
   localparam logic [CfgW-1:0] ExtBits    = 4'd3;
   localparam logic [CfgW-1:0] ByteBits   = 4'd8;
   localparam logic [CfgW-1:0] OneBit     = 4'd1;
   localparam logic [1:0]      CountMore  = 2'd3;
   localparam logic [1:0]      LongCode   = 2'd3;
   localparam logic [2:0]      ExtMore    = 3'd7;
   localparam logic [LenW-1:0] LongLen    = 24'd5;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_OFF_BITS_CODE0 = 2'd0;
   localparam logic [1:0] CSR_OFF_BITS_CODE1 = 2'd1;
   localparam logic [1:0] CSR_OFF_BITS_CODE2 = 2'd2;
   localparam logic [1:0] CSR_OFF_BITS_CODE3 = 2'd3;

   // Request actions; the fourth code acts as a drain.
   typedef enum logic [1:0] {
      ACT_HEADER = 2'd0,
      ACT_DATA   = 2'd1,
      ACT_DRAIN  = 2'd2
   } action_type;

   // Error codes reported with every result.
   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_OVERRUN = 2'd1,
      ERR_OFFSET  = 2'd2,
      ERR_WORD    = 2'd3
   } error_type;

   // Decoder phase, one-hot.
   typedef enum logic [12:0] {
      PH_HEADER  = 13'b0000000000001,
      PH_FIRST   = 13'b0000000000010,
      PH_FLAG    = 13'b0000000000100,
      PH_LITCNT  = 13'b0000000001000,
      PH_LITBYTE = 13'b0000000010000,
      PH_LEN     = 13'b0000000100000,
      PH_ESC     = 13'b0000001000000,
      PH_OFF     = 13'b0000010000000,
      PH_EXT     = 13'b0000100000000,
      PH_COPY    = 13'b0001000000000,
      PH_DONE    = 13'b0010000000000,
      PH_ERR_OVR = 13'b0100000000000,
      PH_ERR_OFF = 13'b1000000000000
   } phase_type;

   // Sequencer state of the request handling, one-hot.
   typedef enum logic [5:0] {
      C_IDLE    = 6'b000001,
      C_SKIP    = 6'b000010,
      C_RUN     = 6'b000100,
      C_COPY    = 6'b001000,
      C_OUTRD   = 6'b010000,
      C_OUTSHOW = 6'b100000
   } ctl_type;

   // Offset width from a register value; values above the maximum act as the maximum.
   function automatic logic [CfgW-1:0] width_for(input logic [CfgW-1:0] w);
      width_for = (w > MaxOffBits) ? MaxOffBits : w;
   endfunction

endpackage
`default_nettype wire

FILE: sv/bldc_req_if.sv
// Interface of the request channel that carries packed words and commands.
`default_nettype none
interface bldc_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [bldc_pkg::WordW-1:0] packed_word;

   modport source(output valid, output action, output packed_word, input ready);
   modport sink(input valid, input action, input packed_word, output ready);
endinterface
`default_nettype wire

FILE: sv/bldc_rsp_if.sv
// Interface of the result channel that carries decoded bytes and status.
`default_nettype none
interface bldc_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] data_byte;
   logic       run_last;
   logic       want_word;
   logic       done_res;
   logic [1:0] error_code;

   modport source(output valid, output byte_valid, output data_byte, output run_last,
                  output want_word, output done_res, output error_code, input ready);
   modport sink(input valid, input byte_valid, input data_byte, input run_last,
                input want_word, input done_res, input error_code, output ready);
endinterface
`default_nettype wire

FILE: sv/bldc_ram.sv
// History window memory with one write port and one registered read port.
`default_nettype none
module bldc_ram (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [bldc_pkg::WinAw-1:0] waddr,
   input  wire logic [7:0]                wdata,
   input  wire logic                      re,
   input  wire logic [bldc_pkg::WinAw-1:0] raddr,
   output logic [7:0]                     rdata
);

   logic [7:0] mem [bldc_pkg::WindowBytes];
   logic [7:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: sv/backward_lz_bitstream_decompressor.sv
// Top level of the backward LZ bitstream decompressor.
// The block takes one request at a time: a header word, a packed data word taken least
// significant bit first, or a drain. Decoding runs one bit per cycle, while a field is
// being read, through a 32-bit shift register; each field is then closed in a step of
// its own, each copied match byte is read from the history and then written, and on the
// first data word the skipped header bits are dropped first. Long matches can reach the
// 64-byte limit of a request. The results, up to 64 per request, are then read back from
// the 8 KiB history window while the receiver is ready, with the final status of the
// request on every one; a request that makes no byte gives one status result only.
`default_nettype none
module backward_lz_bitstream_decompressor (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bldc_req_if.sink                       req,
   bldc_rsp_if.source                     rsp,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [bldc_pkg::CfgW-1:0] csr_data
);

   bldc_pkg::ctl_type   ctl_ff, ctl_in;
   bldc_pkg::phase_type ph_ff, ph_in;
   logic [bldc_pkg::WordW-1:0] buf_ff, buf_in;
   logic [bldc_pkg::LeftW-1:0] left_ff, left_in;
   logic [bldc_pkg::LenW-1:0]  rem_ff, rem_in;
   logic [bldc_pkg::LenW-1:0]  wr_ff, wr_in;
   logic [bldc_pkg::AccW-1:0]  acc_ff, acc_in;
   logic [bldc_pkg::CfgW-1:0]  need_ff, need_in;
   logic [bldc_pkg::LenW-1:0]  run_ff, run_in;
   logic [bldc_pkg::AccW-1:0]  off_ff, off_in;
   logic [bldc_pkg::CntW-1:0]  cnt_ff, cnt_in;
   logic [bldc_pkg::CntW-1:0]  k_ff, k_in;
   logic [bldc_pkg::WinAw-1:0] base_ff, base_in;
   logic                       err3_ff, err3_in;
   logic [bldc_pkg::CfgW-1:0]  cfg_ff [bldc_pkg::NumCfg];
   logic [bldc_pkg::CfgW-1:0]  cfg_in [bldc_pkg::NumCfg];

   logic                       ram_we, ram_re;
   logic [bldc_pkg::WinAw-1:0] ram_waddr, ram_raddr;
   logic [7:0]                 ram_wdata, ram_rdata;

   logic                       decoding, want, last_res;
   logic [bldc_pkg::LenW-1:0]  sum;
   bldc_pkg::ctl_type          out_start;

   bldc_ram u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Phase groups and status after the request.
   assign decoding = (ph_ff == bldc_pkg::PH_FLAG) || (ph_ff == bldc_pkg::PH_LITCNT) ||
                     (ph_ff == bldc_pkg::PH_LITBYTE) || (ph_ff == bldc_pkg::PH_LEN) ||
                     (ph_ff == bldc_pkg::PH_ESC) || (ph_ff == bldc_pkg::PH_OFF) ||
                     (ph_ff == bldc_pkg::PH_EXT) || (ph_ff == bldc_pkg::PH_COPY);
   assign want = (ph_ff == bldc_pkg::PH_FIRST) ||
                 (decoding && (ph_ff != bldc_pkg::PH_COPY) &&
                  (need_ff != '0) && (left_ff == '0));
   assign out_start = (cnt_ff == '0) ? bldc_pkg::C_OUTSHOW : bldc_pkg::C_OUTRD;
   assign last_res = (cnt_ff == '0) || (k_ff + 1'b1 == cnt_ff);

   // Handshake and result fields.
   assign req.ready      = (ctl_ff == bldc_pkg::C_IDLE);
   assign rsp.valid      = (ctl_ff == bldc_pkg::C_OUTSHOW);
   assign rsp.byte_valid = (cnt_ff != '0);
   assign rsp.data_byte  = (cnt_ff != '0) ? ram_rdata : 8'd0;
   assign rsp.run_last   = last_res;
   assign rsp.want_word  = want;
   assign rsp.done_res   = (ph_ff == bldc_pkg::PH_DONE);
   always_comb begin
      if (ph_ff == bldc_pkg::PH_ERR_OVR) begin
         rsp.error_code = bldc_pkg::ERR_OVERRUN;
      end else if (ph_ff == bldc_pkg::PH_ERR_OFF) begin
         rsp.error_code = bldc_pkg::ERR_OFFSET;
      end else if (err3_ff) begin
         rsp.error_code = bldc_pkg::ERR_WORD;
      end else begin
         rsp.error_code = bldc_pkg::ERR_NONE;
      end
   end

   // Sequencer and bit-serial decoder.
   always_comb begin
      ctl_in  = ctl_ff;
      ph_in   = ph_ff;
      buf_in  = buf_ff;
      left_in = left_ff;
      rem_in  = rem_ff;
      wr_in   = wr_ff;
      acc_in  = acc_ff;
      need_in = need_ff;
      run_in  = run_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      base_in = base_ff;
      err3_in = err3_ff;
      cfg_in  = cfg_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = wr_ff[bldc_pkg::WinAw-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = base_ff + bldc_pkg::WinAw'(k_ff);
      sum       = '0;

      if (csr_we) begin
         cfg_in[csr_index] = csr_data;
      end

      unique case (ctl_ff)
         bldc_pkg::C_IDLE: begin
            if (req.valid) begin
               cnt_in  = '0;
               k_in    = '0;
               err3_in = 1'b0;
               base_in = wr_ff[bldc_pkg::WinAw-1:0];
               if (req.action == bldc_pkg::ACT_HEADER) begin
                  rem_in  = req.packed_word[bldc_pkg::WordW-1:8];
                  wr_in   = '0;
                  acc_in  = bldc_pkg::AccW'(req.packed_word[4:0]);
                  need_in = '0;
                  run_in  = '0;
                  off_in  = '0;
                  buf_in  = '0;
                  left_in = '0;
                  ph_in   = (req.packed_word[bldc_pkg::WordW-1:8] != '0) ?
                            bldc_pkg::PH_FIRST : bldc_pkg::PH_DONE;
                  ctl_in  = bldc_pkg::C_OUTSHOW;
               end else if ((ph_ff == bldc_pkg::PH_ERR_OVR) ||
                            (ph_ff == bldc_pkg::PH_ERR_OFF)) begin
                  ctl_in = bldc_pkg::C_OUTSHOW;
               end else if (req.action == bldc_pkg::ACT_DATA) begin
                  if (!want) begin
                     err3_in = 1'b1;
                     ctl_in  = bldc_pkg::C_OUTSHOW;
                  end else begin
                     buf_in  = req.packed_word;
                     left_in = bldc_pkg::LeftW'(bldc_pkg::WordW);
                     ctl_in  = (ph_ff == bldc_pkg::PH_FIRST) ? bldc_pkg::C_SKIP :
                               bldc_pkg::C_RUN;
                  end
               end else begin
                  ctl_in = bldc_pkg::C_RUN;
               end
            end
         end

         // Drop the unused low bits of the first data word, one per cycle.
         bldc_pkg::C_SKIP: begin
            if (acc_ff[4:0] == '0) begin
               ph_in   = bldc_pkg::PH_FLAG;
               need_in = bldc_pkg::OneBit;
               acc_in  = '0;
               ctl_in  = bldc_pkg::C_RUN;
            end else begin
               buf_in  = buf_ff >> 1;
               left_in = left_ff - 1'b1;
               acc_in  = acc_ff - 1'b1;
            end
         end

         bldc_pkg::C_RUN: begin
            if (!decoding || (cnt_ff >= bldc_pkg::CntW'(bldc_pkg::MaxBytes))) begin
               ctl_in = out_start;
            end else if (ph_ff == bldc_pkg::PH_COPY) begin
               ram_re    = 1'b1;
               ram_raddr = wr_ff[bldc_pkg::WinAw-1:0] - 1'b1 - off_ff;
               ctl_in    = bldc_pkg::C_COPY;
            end else if (need_ff != '0) begin
               if (left_ff == '0) begin
                  ctl_in = out_start;
               end else begin
                  acc_in  = {acc_ff[bldc_pkg::AccW-2:0], buf_ff[0]};
                  buf_in  = buf_ff >> 1;
                  left_in = left_ff - 1'b1;
                  need_in = need_ff - 1'b1;
               end
            end else begin
               // Field complete: act on its value.
               unique case (ph_ff)
                  bldc_pkg::PH_FLAG: begin
                     run_in  = '0;
                     ph_in   = acc_ff[0] ? bldc_pkg::PH_LEN : bldc_pkg::PH_LITCNT;
                     need_in = bldc_pkg::LenCodeBits;
                     acc_in  = '0;
                  end
                  bldc_pkg::PH_LITCNT: begin
                     sum    = run_ff + bldc_pkg::LenW'(acc_ff[1:0]);
                     run_in = sum;
                     if (sum >= rem_ff) begin
                        ph_in = bldc_pkg::PH_ERR_OVR;
                     end else if (acc_ff[1:0] == bldc_pkg::CountMore) begin
                        ph_in   = bldc_pkg::PH_LITCNT;
                        need_in = bldc_pkg::LenCodeBits;
                        acc_in  = '0;
                     end else begin
                        run_in  = sum + 1'b1;
                        ph_in   = bldc_pkg::PH_LITBYTE;
                        need_in = bldc_pkg::ByteBits;
                        acc_in  = '0;
                     end
                  end
                  bldc_pkg::PH_LITBYTE: begin
                     ram_we    = 1'b1;
                     ram_wdata = acc_ff[7:0];
                     wr_in     = wr_ff + 1'b1;
                     rem_in    = rem_ff - 1'b1;
                     cnt_in    = cnt_ff + 1'b1;
                     run_in    = run_ff - 1'b1;
                     if (run_ff != bldc_pkg::LenW'(1)) begin
                        ph_in   = bldc_pkg::PH_LITBYTE;
                        need_in = bldc_pkg::ByteBits;
                        acc_in  = '0;
                     end else if (rem_ff == bldc_pkg::LenW'(1)) begin
                        ph_in = bldc_pkg::PH_DONE;
                     end else begin
                        ph_in   = bldc_pkg::PH_LEN;
                        need_in = bldc_pkg::LenCodeBits;
                        acc_in  = '0;
                     end
                  end
                  bldc_pkg::PH_LEN: begin
                     run_in = bldc_pkg::LenW'(acc_ff[1:0]) + bldc_pkg::LenW'(2);
                     acc_in = '0;
                     if (acc_ff[1:0] == bldc_pkg::LongCode) begin
                        ph_in   = bldc_pkg::PH_ESC;
                        need_in = bldc_pkg::OneBit;
                     end else begin
                        ph_in   = bldc_pkg::PH_OFF;
                        need_in = bldc_pkg::width_for(cfg_ff[acc_ff[1:0]]);
                     end
                  end
                  bldc_pkg::PH_ESC: begin
                     ph_in   = bldc_pkg::PH_OFF;
                     need_in = acc_ff[0] ? bldc_pkg::width_for(cfg_ff[bldc_pkg::CSR_OFF_BITS_CODE3])
                                         : bldc_pkg::EscOffBits;
                     acc_in  = '0;
                  end
                  bldc_pkg::PH_OFF: begin
                     off_in = acc_ff;
                     if (bldc_pkg::LenW'(acc_ff) >= wr_ff) begin
                        ph_in = bldc_pkg::PH_ERR_OFF;
                     end else if (run_ff == bldc_pkg::LongLen) begin
                        ph_in   = bldc_pkg::PH_EXT;
                        need_in = bldc_pkg::ExtBits;
                        acc_in  = '0;
                     end else if (run_ff > rem_ff) begin
                        ph_in = bldc_pkg::PH_ERR_OVR;
                     end else begin
                        ph_in = bldc_pkg::PH_COPY;
                     end
                  end
                  bldc_pkg::PH_EXT: begin
                     sum    = run_ff + bldc_pkg::LenW'(acc_ff[2:0]);
                     run_in = sum;
                     if (sum > rem_ff) begin
                        ph_in = bldc_pkg::PH_ERR_OVR;
                     end else if (acc_ff[2:0] == bldc_pkg::ExtMore) begin
                        ph_in   = bldc_pkg::PH_EXT;
                        need_in = bldc_pkg::ExtBits;
                        acc_in  = '0;
                     end else begin
                        ph_in = bldc_pkg::PH_COPY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Write the match byte read from the window in the previous cycle.
         bldc_pkg::C_COPY: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            wr_in     = wr_ff + 1'b1;
            rem_in    = rem_ff - 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            run_in    = run_ff - 1'b1;
            if (run_ff == bldc_pkg::LenW'(1)) begin
               if (rem_ff == bldc_pkg::LenW'(1)) begin
                  ph_in = bldc_pkg::PH_DONE;
               end else begin
                  ph_in   = bldc_pkg::PH_FLAG;
                  need_in = bldc_pkg::OneBit;
                  acc_in  = '0;
               end
            end
            ctl_in = bldc_pkg::C_RUN;
         end

         // Read back the bytes of this request from the window.
         bldc_pkg::C_OUTRD: begin
            ram_re = 1'b1;
            ctl_in = bldc_pkg::C_OUTSHOW;
         end

         bldc_pkg::C_OUTSHOW: begin
            if (rsp.ready) begin
               if (last_res) begin
                  ctl_in = bldc_pkg::C_IDLE;
               end else begin
                  k_in   = k_ff + 1'b1;
                  ctl_in = bldc_pkg::C_OUTRD;
               end
            end
         end

         default: begin
            ctl_in = bldc_pkg::C_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= bldc_pkg::C_IDLE;
         ph_ff     <= bldc_pkg::PH_HEADER;
         buf_ff    <= '0;
         left_ff   <= '0;
         rem_ff    <= '0;
         wr_ff     <= '0;
         acc_ff    <= '0;
         need_ff   <= '0;
         run_ff    <= '0;
         off_ff    <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
         base_ff   <= '0;
         err3_ff   <= 1'b0;
         cfg_ff[0] <= 4'd9;
         cfg_ff[1] <= 4'd10;
         cfg_ff[2] <= 4'd12;
         cfg_ff[3] <= 4'd13;
      end else begin
         ctl_ff  <= ctl_in;
         ph_ff   <= ph_in;
         buf_ff  <= buf_in;
         left_ff <= left_in;
         rem_ff  <= rem_in;
         wr_ff   <= wr_in;
         acc_ff  <= acc_in;
         need_ff <= need_in;
         run_ff  <= run_in;
         off_ff  <= off_in;
         cnt_ff  <= cnt_in;
         k_ff    <= k_in;
         base_ff <= base_in;
         err3_ff <= err3_in;
         cfg_ff  <= cfg_in;
      end
   end

`ifndef SYNTHESIS
   // A status-only result is always the last one of its request.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.byte_valid) |-> rsp.run_last)
      else $error("status-only result not marked last");

   // No new request is taken while a result is being offered.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid)
      else $error("request taken while a result is pending");

   // A request never yields more bytes than the per-request limit.
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bldc_pkg::CntW'(bldc_pkg::MaxBytes))
      else $error("byte count above limit");
`endif

endmodule
`default_nettype wire
